>>> src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the spherical to Cartesian converter.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int PHASE_W = 32;
  localparam int Q30_W   = 31;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [Q30_W-1:0]   Q30_ONE      = 31'h4000_0000;

  localparam logic [30:0] POLY_A = 31'd1686629713;
  localparam logic [29:0] POLY_B = 30'd688904866;
  localparam logic [26:0] POLY_C = 27'd76016977;

  localparam int RAD_W = 16;
  localparam int MAG_W = 17;

  typedef struct packed {
    logic [Q30_W-1:0] mag;
    logic             neg;
  } trig_t;

  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
  } trig_en_t;

endpackage

>>> src/stc_in_if.sv
// ----------------------------------------------------------------------------
// stc_in_if
// Request channel of the converter: radius and two angle phases.
// ----------------------------------------------------------------------------
interface stc_in_if #(
  parameter int ANGLE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [15:0]           radius_frac;
  logic [ANGLE_BITS-1:0] azimuth_phase;
  logic [ANGLE_BITS-1:0] polar_phase;

  modport source (output valid, input ready, output radius_frac, output azimuth_phase,
                  output polar_phase);
  modport sink   (input valid, output ready, input radius_frac, input azimuth_phase,
                  input polar_phase);
endinterface

>>> src/stc_out_if.sv
// ----------------------------------------------------------------------------
// stc_out_if
// Result channel of the converter: signed Cartesian coordinates.
// ----------------------------------------------------------------------------
interface stc_out_if #(
  parameter int COORD_BITS = 17
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, input ready, output pos_x, output pos_y, output pos_z);
  modport sink   (input valid, output ready, input pos_x, input pos_y, input pos_z);
endinterface

>>> src/stc_sine.sv
// ----------------------------------------------------------------------------
// stc_sine
// Four-stage sine of a 32-bit phase: odd 5th-order polynomial on the
// quarter wave in Q30, one multiplier per stage, clamped magnitude and sign.
// ----------------------------------------------------------------------------
module stc_sine (
  input  logic                               clk,
  input  stc_pkg::trig_en_t                  en,
  input  logic [stc_pkg::PHASE_W-1:0]        phase,
  output stc_pkg::trig_t                     result
);

  logic [29:0]               frac;
  logic [stc_pkg::Q30_W-1:0] z0;
  logic [61:0]               zz_prod;
  logic [57:0]               cz_prod;
  logic [60:0]               tz_prod;
  logic [61:0]               uz_prod;
  logic [31:0]               s_full;
  logic [stc_pkg::Q30_W-1:0] s_clamp;

  logic [stc_pkg::Q30_W-1:0] z1_r, z2_r, z3_r;
  logic [stc_pkg::Q30_W-1:0] zsq1_r, zsq2_r;
  logic                      q1_r, q2_r, q3_r;
  logic [29:0]               t2_r;
  logic [30:0]               u3_r;
  stc_pkg::trig_t            res_r;

  assign frac    = phase[29:0];
  assign z0      = phase[30] ? (stc_pkg::Q30_ONE - {1'b0, frac}) : {1'b0, frac};
  assign zz_prod = z0 * z0;
  assign cz_prod = stc_pkg::POLY_C * zsq1_r;
  assign tz_prod = t2_r * zsq2_r;
  assign uz_prod = u3_r * z3_r;
  assign s_full  = uz_prod[61:30];
  assign s_clamp = (s_full > {1'b0, stc_pkg::Q30_ONE}) ? stc_pkg::Q30_ONE
                                                        : s_full[stc_pkg::Q30_W-1:0];

  always_ff @(posedge clk) begin
    if (en.s0) begin
      z1_r   <= z0;
      zsq1_r <= zz_prod[60:30];
      q1_r   <= phase[31];
    end
    if (en.s1) begin
      z2_r   <= z1_r;
      zsq2_r <= zsq1_r;
      q2_r   <= q1_r;
      t2_r   <= stc_pkg::POLY_B - {2'b00, cz_prod[57:30]};
    end
    if (en.s2) begin
      z3_r <= z2_r;
      q3_r <= q2_r;
      u3_r <= stc_pkg::POLY_A - tz_prod[60:30];
    end
    if (en.s3) begin
      res_r.mag <= s_clamp;
      res_r.neg <= q3_r && (s_clamp != '0);
    end
  end

  assign result = res_r;

endmodule

>>> src/spherical_to_cartesian_unit.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian_unit
// Converts a radius and two angle phases into x, y and z coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request: radius_frac (Q0.16), azimuth_phase and
//   polar_phase (2^ANGLE_BITS is a full turn). out_chan returns pos_x,
//   pos_y and pos_z, signed, 32768 per unit length, saturated to COORD_BITS.
//   A request is taken at a clock edge with valid and ready both high.
//   The pipeline has seven register stages, and out_chan.valid rises once a
//   request has passed through all of them.
//   Stages: four for the polynomial sine units (one multiplier each), one for
//   the angle products, one for the radius scaling and rounding, and the
//   output register. Throughput is one request per cycle while out_chan.ready is high.
//   Every stage holds its own valid bit and advances when the next stage is
//   free, so bubbles close up while out_chan is stalled; in_chan.ready falls
//   only once all seven stages are full and out_chan.ready is low.
//   A synchronous low rst_n empties the pipeline; no state survives a request.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 17
) (
  input  logic     clk,
  input  logic     rst_n,
  stc_in_if.sink   in_chan,
  stc_out_if.source out_chan
);

  localparam int NSTG = 7;
  localparam logic [32:0] POS_MAX = (33'd1 << (COORD_BITS - 1)) - 33'd1;
  localparam logic [32:0] NEG_MAX = 33'd1 << (COORD_BITS - 1);

  logic [NSTG-1:0] valid_r, valid_nxt, ld;
  logic [NSTG:0]   rdy;

  logic [stc_pkg::PHASE_W-1:0] th_phase, th_cos_phase, ph_phase, ph_cos_phase;
  stc_pkg::trig_en_t           trig_en;
  stc_pkg::trig_t              sth, cth, sph, cph;

  logic [stc_pkg::RAD_W-1:0] rad_r [4];
  logic [stc_pkg::RAD_W-1:0] rad4_r;
  logic [stc_pkg::Q30_W-1:0] mx_r, my_r, mz_r;
  logic                      nx4_r, ny4_r, nz4_r;
  logic [61:0]               mx_prod, my_prod;

  logic [47:0]               rx_sum, ry_sum, rz_sum;
  logic [stc_pkg::MAG_W-1:0] magx_r, magy_r, magz_r;
  logic                      nx5_r, ny5_r, nz5_r;

  logic signed [COORD_BITS-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [COORD_BITS-1:0]        enc_x, enc_y, enc_z;

  function automatic logic [32:0] encode(input logic [stc_pkg::MAG_W-1:0] mag,
                                         input logic neg,
                                         input logic [32:0] pmax,
                                         input logic [32:0] nmax);
    logic [32:0] m;
    logic [32:0] s;
    m = {16'd0, mag};
    if (neg) begin
      s = (m > nmax) ? nmax : m;
      s = 33'd0 - s;
    end else begin
      s = (m > pmax) ? pmax : m;
    end
    return s;
  endfunction

  // stage handshake: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NSTG] = out_chan.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    ld = rdy[NSTG-1:0];
    valid_nxt = valid_r;
    if (ld[0]) begin
      valid_nxt[0] = in_chan.valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_chan.ready = rdy[0];

  // angle phases
  assign th_phase     = stc_pkg::PHASE_W'(in_chan.azimuth_phase) << (32 - ANGLE_BITS);
  assign ph_phase     = stc_pkg::PHASE_W'(in_chan.polar_phase) << (32 - ANGLE_BITS);
  assign th_cos_phase = th_phase + stc_pkg::QUARTER_TURN;
  assign ph_cos_phase = ph_phase + stc_pkg::QUARTER_TURN;

  assign trig_en.s0 = ld[0];
  assign trig_en.s1 = ld[1];
  assign trig_en.s2 = ld[2];
  assign trig_en.s3 = ld[3];

  stc_sine u_sin_th (.clk(clk), .en(trig_en), .phase(th_phase),     .result(sth));
  stc_sine u_cos_th (.clk(clk), .en(trig_en), .phase(th_cos_phase), .result(cth));
  stc_sine u_sin_ph (.clk(clk), .en(trig_en), .phase(ph_phase),     .result(sph));
  stc_sine u_cos_ph (.clk(clk), .en(trig_en), .phase(ph_cos_phase), .result(cph));

  // radius travels alongside the sine stages
  always_ff @(posedge clk) begin
    if (ld[0]) rad_r[0] <= in_chan.radius_frac;
    for (int k = 1; k < 4; k++) begin
      if (ld[k]) rad_r[k] <= rad_r[k-1];
    end
  end

  // angle products
  assign mx_prod = sph.mag * cth.mag;
  assign my_prod = sph.mag * sth.mag;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      rad4_r <= rad_r[3];
      mx_r   <= mx_prod[60:30];
      my_r   <= my_prod[60:30];
      mz_r   <= cph.mag;
      nx4_r  <= sph.neg ^ cth.neg;
      ny4_r  <= sph.neg ^ sth.neg;
      nz4_r  <= cph.neg;
    end
  end

  // radius scaling, round half away from zero into Q15
  assign rx_sum = 48'(rad4_r) * 48'(mx_r) + 48'h4000_0000;
  assign ry_sum = 48'(rad4_r) * 48'(my_r) + 48'h4000_0000;
  assign rz_sum = 48'(rad4_r) * 48'(mz_r) + 48'h4000_0000;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      magx_r <= rx_sum[47:31];
      magy_r <= ry_sum[47:31];
      magz_r <= rz_sum[47:31];
      nx5_r  <= nx4_r;
      ny5_r  <= ny4_r;
      nz5_r  <= nz4_r;
    end
  end

  // sign, saturate and register the result
  always_comb begin
    enc_x = COORD_BITS'(encode(magx_r, nx5_r, POS_MAX, NEG_MAX));
    enc_y = COORD_BITS'(encode(magy_r, ny5_r, POS_MAX, NEG_MAX));
    enc_z = COORD_BITS'(encode(magz_r, nz5_r, POS_MAX, NEG_MAX));
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      pos_x_r <= enc_x;
      pos_y_r <= enc_y;
      pos_z_r <= enc_z;
    end
  end

  assign out_chan.valid = valid_r[NSTG-1];
  assign out_chan.pos_x = pos_x_r;
  assign out_chan.pos_y = pos_y_r;
  assign out_chan.pos_z = pos_z_r;

endmodule

>>> src/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module stc_checker #(
  parameter int COORD_BITS = 17
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] pos_x,
  input logic signed [COORD_BITS-1:0] pos_y,
  input logic signed [COORD_BITS-1:0] pos_z
);

  // pipeline empties at reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // back-pressure reaches the request side only from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("request side stalled without a stalled result");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(pos_y)
                                   && $stable(pos_z)))
    else $error("stalled result dropped or changed");

  // a full pipeline that is drained frees the request side
  a_drain_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready && !in_valid) |=> in_ready)
    else $error("request side still stalled after a drain cycle");

endmodule

bind spherical_to_cartesian_unit stc_checker #(.COORD_BITS(COORD_BITS)) u_stc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pos_x     (out_chan.pos_x),
  .pos_y     (out_chan.pos_y),
  .pos_z     (out_chan.pos_z)
);

>>> sim/spherical_to_cartesian_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spherical_to_cartesian_checker
// This monitor watches the request and result channels of the converter.
// For every accepted request it computes the expected x, y and z in fixed
// point: quarter-wave polynomial sine, products on magnitudes with a separate
// sign, half-away rounding and saturation. Results are compared field by
// field, in order, against the queued points.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_checker #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 17
) (
  input  logic clk,
  input  logic rst_n,
  stc_in_if    in_mon,
  stc_out_if   out_mon,
  output int   pending,
  output int   checked,
  output int   fail_count
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } cartesian_t;

  cartesian_t expected_points[$];

  function automatic stc_pkg::trig_t poly_sine(input logic [stc_pkg::PHASE_W-1:0] phase);
    logic [1:0]     quad;
    logic [63:0]    frac, zv, z2, t, u, s;
    stc_pkg::trig_t res;
    quad = phase[31:30];
    frac = 64'(phase[29:0]);
    zv   = quad[0] ? (64'(stc_pkg::Q30_ONE) - frac) : frac;
    z2   = (zv * zv) >> 30;
    t    = 64'(stc_pkg::POLY_B) - ((64'(stc_pkg::POLY_C) * z2) >> 30);
    u    = 64'(stc_pkg::POLY_A) - ((t * z2) >> 30);
    s    = (u * zv) >> 30;
    if (s > 64'(stc_pkg::Q30_ONE)) s = 64'(stc_pkg::Q30_ONE);
    res.mag = s[stc_pkg::Q30_W-1:0];
    res.neg = quad[1] && (s != 64'd0);
    return res;
  endfunction

  function automatic logic [COORD_BITS-1:0] scale_coord(input logic [63:0] r,
                                                        input logic [63:0] m,
                                                        input logic neg);
    logic [63:0] mag, pos_max, neg_max;
    mag     = (r * m + (64'd1 << 30)) >> 31;
    pos_max = (64'd1 << (COORD_BITS - 1)) - 64'd1;
    neg_max = 64'd1 << (COORD_BITS - 1);
    if (mag == 64'd0) return '0;
    if (neg) begin
      if (mag > neg_max) mag = neg_max;
      mag = 64'd0 - mag;
    end else if (mag > pos_max) begin
      mag = pos_max;
    end
    return mag[COORD_BITS-1:0];
  endfunction

  function automatic cartesian_t convert_point(input logic [stc_pkg::RAD_W-1:0] radius,
                                               input logic [ANGLE_BITS-1:0] azimuth,
                                               input logic [ANGLE_BITS-1:0] polar);
    logic [stc_pkg::PHASE_W-1:0] az_ph, pol_ph;
    stc_pkg::trig_t              sin_az, cos_az, sin_pol, cos_pol;
    logic [63:0]                 r, mx, my;
    cartesian_t                  pt;
    az_ph   = stc_pkg::PHASE_W'(azimuth) << (stc_pkg::PHASE_W - ANGLE_BITS);
    pol_ph  = stc_pkg::PHASE_W'(polar) << (stc_pkg::PHASE_W - ANGLE_BITS);
    sin_az  = poly_sine(az_ph);
    cos_az  = poly_sine(az_ph + stc_pkg::QUARTER_TURN);
    sin_pol = poly_sine(pol_ph);
    cos_pol = poly_sine(pol_ph + stc_pkg::QUARTER_TURN);
    r  = 64'(radius);
    mx = (64'(sin_pol.mag) * 64'(cos_az.mag)) >> 30;
    my = (64'(sin_pol.mag) * 64'(sin_az.mag)) >> 30;
    pt.x = scale_coord(r, mx, sin_pol.neg != cos_az.neg);
    pt.y = scale_coord(r, my, sin_pol.neg != sin_az.neg);
    pt.z = scale_coord(r, 64'(cos_pol.mag), cos_pol.neg);
    return pt;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_coord(input string name,
                               input logic signed [COORD_BITS-1:0] got,
                               input logic signed [COORD_BITS-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                checked, name, got, want));
  endtask

  always @(posedge clk) begin : watch_channels
    cartesian_t got, want;
    if (!rst_n) begin
      expected_points.delete();
      checked    = 0;
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pos_x, out_mon.pos_y, out_mon.pos_z};
        checked++;
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d, %0d) with no request waiting",
                                    got.x, got.y, got.z));
        end else begin
          want = expected_points.pop_front();
          compare_coord("pos_x", got.x, want.x);
          compare_coord("pos_y", got.y, want.y);
          compare_coord("pos_z", got.z, want.z);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_points.push_back(convert_point(in_mon.radius_frac, in_mon.azimuth_phase,
                                                in_mon.polar_phase));
    end
    pending <= expected_points.size();
  end

endmodule

>>> sim/spherical_to_cartesian_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spherical_to_cartesian_unit_tb
// This testbench drives the converter with directed corner points (full and
// zero radius, axis and quadrant-edge angles, negative sine and cosine) and
// then with about 1250 random points. It runs under three back-pressure
// mixes, with two long output hold-offs and one mid-run drain. The checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_unit_tb;

  localparam int ANGLE_BITS   = 16;
  localparam int COORD_BITS   = 17;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_PER_MIX = 417;
  localparam int DIRECTED_N   = 20;

  localparam logic [47:0] DIRECTED_POINTS [DIRECTED_N] = '{
    {16'h0000, 16'h0000, 16'h0000}, {16'hFFFF, 16'h0000, 16'h0000},
    {16'hFFFF, 16'h0000, 16'h8000}, {16'hFFFF, 16'h0000, 16'h4000},
    {16'hFFFF, 16'h4000, 16'h4000}, {16'hFFFF, 16'h8000, 16'h4000},
    {16'hFFFF, 16'hC000, 16'h4000}, {16'hFFFF, 16'h0000, 16'hC000},
    {16'h0000, 16'h8000, 16'h8000}, {16'h0001, 16'h0000, 16'h0000},
    {16'h0001, 16'h2000, 16'h2000}, {16'h8000, 16'h2000, 16'h2000},
    {16'hFFFF, 16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'h0001, 16'h0001},
    {16'hFFFF, 16'h3FFF, 16'hBFFF}, {16'hFFFF, 16'h4001, 16'h7FFF},
    {16'hAAAA, 16'h5555, 16'hAAAA}, {16'h5555, 16'hAAAA, 16'h5555},
    {16'hFFFF, 16'hE000, 16'hA000}, {16'h7FFF, 16'h1234, 16'hEDCB}
  };

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_id;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;
  int   sent_count;
  int   pending;
  int   checked_count;
  int   fail_count;

  stc_in_if  #(.ANGLE_BITS(ANGLE_BITS)) in_chan ();
  stc_out_if #(.COORD_BITS(COORD_BITS)) out_chan ();

  spherical_to_cartesian_unit #(
    .ANGLE_BITS(ANGLE_BITS),
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  spherical_to_cartesian_checker #(
    .ANGLE_BITS(ANGLE_BITS),
    .COORD_BITS(COORD_BITS)
  ) point_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .pending   (pending),
    .checked   (checked_count),
    .fail_count(fail_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    logic [ANGLE_BITS-1:0] quarter;
    quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    if ($urandom_range(3, 0) == 0)
      return ANGLE_BITS'(quarter * $urandom_range(3, 0) + $urandom_range(4, 0) - 2);
    return ANGLE_BITS'($urandom());
  endfunction

  task automatic send_point(input logic [stc_pkg::RAD_W-1:0] radius,
                            input logic [ANGLE_BITS-1:0] azimuth,
                            input logic [ANGLE_BITS-1:0] polar);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.radius_frac   <= radius;
    in_chan.azimuth_phase <= azimuth;
    in_chan.polar_phase   <= polar;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_points();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_id != hold_seen) begin
        hold_seen = hold_id;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("spherical_to_cartesian_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [stc_pkg::RAD_W-1:0] radius;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.radius_frac   <= '0;
    in_chan.azimuth_phase <= '0;
    in_chan.polar_phase   <= '0;
    hold_id               <= 0;
    rx_idle_pct           <= 69;
    tx_idle_pct  = 12;
    sent_count   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_POINTS[i])
      send_point(DIRECTED_POINTS[i][47:32], DIRECTED_POINTS[i][31:16],
                 DIRECTED_POINTS[i][15:0]);

    for (int mix = 0; mix < 3; mix++) begin
      tx_idle_pct = (mix == 0) ? 12 : (mix == 1) ? 69 : 0;
      rx_idle_pct <= (mix == 0) ? 69 : (mix == 1) ? 12 : 0;
      for (int i = 0; i < RANDOM_PER_MIX; i++) begin
        // stall the output while requests keep coming (mix 1 drains instead)
        if (mix != 1 && i == 200) hold_id <= hold_id + 1;
        if (mix == 1 && i == 200) drain_points();
        if ($urandom_range(9, 0) == 0)
          radius = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
        else
          radius = stc_pkg::RAD_W'($urandom());
        send_point(radius, pick_angle(), pick_angle());
      end
    end

    drain_points();
    repeat (16) @(posedge clk);
    $display("Sent %0d points (axis, quadrant-edge and extreme radius cases, then random)",
             sent_count);
    $display("and checked %0d results under three stall mixes, a long hold-off and a drain",
             checked_count);
    if (fail_count == 0 && pending == 0)
      $display("spherical_to_cartesian_unit_tb OK");
    else
      $display("spherical_to_cartesian_unit_tb NOT OK");
    $finish;
  end

endmodule

>>> sim.f
src/stc_pkg.sv
src/stc_in_if.sv
src/stc_out_if.sv
src/stc_sine.sv
src/spherical_to_cartesian_unit.sv
src/stc_checker.sv
sim/spherical_to_cartesian_checker.sv
sim/spherical_to_cartesian_unit_tb.sv
